/* rtl/sensorless_six_step_commutator_unit_defines.svh */
// Assertion macros for the sensorless six-step commutator unit.
// Uses the clk_i and rst_ni names of the including module.
`ifndef SENSORLESS_SIX_STEP_COMMUTATOR_UNIT_DEFINES_SVH
`define SENSORLESS_SIX_STEP_COMMUTATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define SSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ssc_pkg.sv */
// Package for the sensorless six-step commutator unit.
// Holds the result type, step tables, item codes and reset constants; no dependencies.
package ssc_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam logic [15:0] START_PERIOD_RST = 16'd162;
  localparam logic [2:0]  PHASE_LAST = 3'd5;

  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  high_gates;
    logic [2:0]  low_gates;
    logic [1:0]  sense_channel;
    logic [15:0] period_ticks;
    logic        zero_cross;
    logic        commutated;
  } result_t;

  function automatic logic [2:0] high_gates_f(logic [2:0] ph);
    case (ph)
      3'd0, 3'd1: high_gates_f = 3'd2;
      3'd2, 3'd3: high_gates_f = 3'd4;
      3'd4, 3'd5: high_gates_f = 3'd1;
      default:    high_gates_f = 3'd2;
    endcase
  endfunction

  function automatic logic [2:0] low_gates_f(logic [2:0] ph);
    case (ph)
      3'd0:       low_gates_f = 3'd4;
      3'd1, 3'd2: low_gates_f = 3'd1;
      3'd3, 3'd4: low_gates_f = 3'd2;
      3'd5:       low_gates_f = 3'd4;
      default:    low_gates_f = 3'd4;
    endcase
  endfunction

  function automatic logic [1:0] sense_channel_f(logic [2:0] ph);
    case (ph)
      3'd0, 3'd3: sense_channel_f = 2'd2;
      3'd1, 3'd4: sense_channel_f = 2'd1;
      3'd2, 3'd5: sense_channel_f = 2'd0;
      default:    sense_channel_f = 2'd2;
    endcase
  endfunction

  // round 16.8 period to ticks, saturate at 16 bits
  function automatic logic [15:0] round_period_f(logic [23:0] pf);
    logic [24:0] sum;
    sum = {1'b0, pf} + 25'd128;
    round_period_f = sum[24] ? 16'hFFFF : sum[23:8];
  endfunction

endpackage

/* rtl/sensorless_six_step_commutator_unit.sv */
// Sensorless six-step commutator: step timer, back-EMF zero-cross and period tracking.
// Depends on ssc_pkg and sensorless_six_step_commutator_unit_defines.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request per cycle unless stalled:
//   cmd_i = tick advances the step counter; cmd_i = sample carries the
//   floating-phase back-EMF and neutral ADC values (low SAMPLE_BITS bits).
//   Every request yields one result on the output channel (out_valid_o /
//   out_stall_i): step, gate patterns, sense channel, rounded period and
//   the zero_cross / commutated flags, all taken after the request.
//   Each result is registered into the output register, or into the skid entry while
//   the output is held. Throughput is one request per cycle while in_stall_o is low,
//   as the step, counter, period and neutral registers feed the next request directly.
//   cfg_we_i / cfg_wdata_i load the start period (ticks) into the period
//   register; write only while idle.
//   Reset: step 0, counter 0, neutral 0, detection disarmed, period 162
//   ticks, no result pending.
//   Receiver stall: a two-entry output stage holds results; in_stall_o
//   rises only once both entries are full.
`include "sensorless_six_step_commutator_unit_defines.svh"

module sensorless_six_step_commutator_unit #(
  parameter int unsigned SAMPLE_BITS = ssc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [15:0]            cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   cmd_i,
  input  logic [SAMPLE_BITS-1:0] bemf_sample_i,
  input  logic [SAMPLE_BITS-1:0] neutral_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             phase_o,
  output logic [2:0]             high_gates_o,
  output logic [2:0]             low_gates_o,
  output logic [1:0]             sense_channel_o,
  output logic [15:0]            period_ticks_o,
  output logic                   zero_cross_o,
  output logic                   commutated_o
);
  import ssc_pkg::*;

  localparam int unsigned PS_W = 30;
  localparam int unsigned PX_W = PS_W - 3;
  localparam int unsigned PK   = 30;
  localparam int unsigned PM_W = 28;
  localparam int unsigned PP_W = PX_W + PM_W;
  localparam logic [63:0] PMUL64 = ((64'd1 << PK) + 64'd4) / 64'd5;
  localparam logic [PM_W-1:0] PMUL = PMUL64[PM_W-1:0];

  localparam int unsigned NW     = SAMPLE_BITS + 8;
  localparam int unsigned NSUM_W = NW + 9;
  localparam int unsigned NY_W   = NW + 7;
  localparam int unsigned NK     = SAMPLE_BITS + 22;
  localparam int unsigned NM_W   = SAMPLE_BITS + 16;
  localparam int unsigned NP_W   = NY_W + NM_W;
  localparam logic [63:0] NMUL64 = ((64'd1 << NK) + 64'd74) / 64'd75;
  localparam logic [NM_W-1:0] NMUL = NMUL64[NM_W-1:0];

  logic [2:0]    step_q, step_d;
  logic [15:0]   tc_q, tc_d;
  logic [23:0]   pf_q, pf_d;
  logic [NW-1:0] nf_q, nf_d;
  logic          armed_q, armed_d;

  logic          out_valid_q, out_valid_d;
  logic          skid_valid_q, skid_valid_d;
  result_t       out_q, out_d;
  result_t       skid_q, skid_d;
  result_t       res;

  logic              in_fire, out_fire;
  logic [15:0]       cur_period;
  logic [16:0]       tick_next;
  logic              commute;
  logic [NW-1:0]     bemf_ext;
  logic              cross_raw, hit;
  logic [PS_W-1:0]   psum;
  logic [PP_W-1:0]   pprod;
  logic [24:0]       pquo;
  logic [23:0]       pnew;
  logic [NSUM_W-1:0] nsum;
  logic [NY_W-1:0]   ny;
  logic [NP_W-1:0]   nprod;
  logic [NW-1:0]     nnew;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;

  always_comb begin
    cur_period = round_period_f(pf_q);
    tick_next  = {1'b0, tc_q} + 17'd1;
    commute    = tick_next >= {1'b0, cur_period};

    bemf_ext  = {bemf_sample_i, 8'b0};
    cross_raw = step_q[0] ? (bemf_ext > nf_q) : (bemf_ext < nf_q);
    hit       = armed_q && (tc_q != 16'd0) && cross_raw;

    psum  = (PS_W'(pf_q) * PS_W'(39)) + PS_W'({tc_q, 9'b0}) + PS_W'(20);
    pprod = PP_W'(psum[PS_W-1:3]) * PP_W'(PMUL);
    pquo  = pprod[PK +: 25];
    pnew  = pquo[24] ? 24'hFFFFFF : pquo[23:0];

    nsum  = NSUM_W'({neutral_sample_i, 8'b0}) + (NSUM_W'(nf_q) * NSUM_W'(299))
            + NSUM_W'(150);
    ny    = nsum[NSUM_W-1:2];
    nprod = NP_W'(ny) * NP_W'(NMUL);
    nnew  = nprod[NK +: NW];
  end

  always_comb begin
    step_d  = step_q;
    tc_d    = tc_q;
    pf_d    = pf_q;
    nf_d    = nf_q;
    armed_d = armed_q;
    res.zero_cross = 1'b0;
    res.commutated = 1'b0;
    if (in_fire) begin
      if (cmd_i == CMD_TICK) begin
        if (commute) begin
          step_d  = (step_q >= PHASE_LAST) ? 3'd0 : step_q + 3'd1;
          tc_d    = 16'd0;
          armed_d = 1'b1;
          res.commutated = 1'b1;
        end else begin
          tc_d = tick_next[15:0];
        end
      end else begin
        if (hit) begin
          pf_d    = pnew;
          armed_d = 1'b0;
          res.zero_cross = 1'b1;
        end
        nf_d = nnew;
      end
    end
    if (cfg_we_i) begin
      pf_d = {cfg_wdata_i, 8'b0};
    end
    res.phase         = step_d;
    res.high_gates    = high_gates_f(step_d);
    res.low_gates     = low_gates_f(step_d);
    res.sense_channel = sense_channel_f(step_d);
    res.period_ticks  = round_period_f(pf_d);
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= 3'd0;
      tc_q         <= 16'd0;
      pf_q         <= {START_PERIOD_RST, 8'b0};
      nf_q         <= '0;
      armed_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      step_q       <= step_d;
      tc_q         <= tc_d;
      pf_q         <= pf_d;
      nf_q         <= nf_d;
      armed_q      <= armed_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_valid_q;
  assign phase_o         = out_q.phase;
  assign high_gates_o    = out_q.high_gates;
  assign low_gates_o     = out_q.low_gates;
  assign sense_channel_o = out_q.sense_channel;
  assign period_ticks_o  = out_q.period_ticks;
  assign zero_cross_o    = out_q.zero_cross;
  assign commutated_o    = out_q.commutated;

  `SSC_ASSERT_IMP(a_skid_needs_out, skid_valid_q, out_valid_q, "skid full with output empty")
  `SSC_ASSERT_IMP(a_step_range, 1'b1, step_q <= PHASE_LAST, "step out of range")
  `SSC_ASSERT_NXT(a_commute_arms, in_fire && (cmd_i == CMD_TICK) && commute && !cfg_we_i,
                  armed_q && (tc_q == 16'd0), "commutation did not arm detection")
  `SSC_ASSERT_IMP(a_flags_excl, out_valid_q, !(out_q.zero_cross && out_q.commutated),
                  "zero_cross and commutated both set")

endmodule

/* verif/tb.sv */
// Self-checking bench for the sensorless six-step commutator unit.
// Predicts step, gates, period tracking and neutral filter per request; needs ssc_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
  import ssc_pkg::*;

  localparam int unsigned SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int unsigned IDLE_PCT = 38;
  localparam int unsigned PHASE_ITEMS = 245;
  localparam logic [15:0] PHASE_PERIODS [7] = '{16'd2, 16'd5, 16'd1, 16'd162, 16'd12,
                                                16'd40, 16'd300};

  class commutation_scoreboard;
    logic [2:0]          step;
    logic [15:0]         ticks;
    logic [23:0]         period_fx;
    logic [SAMPLE_W+7:0] neutral_fx;
    bit                  armed;
    result_t             expected_q[$];
    int unsigned         errors;
    int unsigned         requests;
    int unsigned         commutations;
    int unsigned         crossings;

    function new();
      step = 3'd0;
      ticks = 16'd0;
      period_fx = {START_PERIOD_RST, 8'h00};
      neutral_fx = '0;
      armed = 1'b0;
      errors = 0;
      requests = 0;
      commutations = 0;
      crossings = 0;
    endfunction

    function void load_period(logic [15:0] v);
      period_fx = {v, 8'h00};
    endfunction

    function logic [15:0] rounded_period();
      logic [31:0] p;
      p = ({8'h00, period_fx} + 32'd128) >> 8;
      return (p > 32'd65535) ? 16'hFFFF : p[15:0];
    endfunction

    function void note_request(cmd_e cmd, logic [SAMPLE_W-1:0] bemf,
                               logic [SAMPLE_W-1:0] neu);
      logic [63:0] acc;
      logic [31:0] c;
      bit          zc;
      bit          com;
      bit          hit;
      result_t     r;
      zc = 1'b0;
      com = 1'b0;
      requests++;
      if (cmd == CMD_TICK) begin
        c = {16'h0000, ticks} + 32'd1;
        if (c >= {16'h0000, rounded_period()}) begin
          step = (step >= PHASE_LAST) ? 3'd0 : step + 3'd1;
          ticks = 16'd0;
          armed = 1'b1;
          com = 1'b1;
          commutations++;
        end else begin
          ticks = c[15:0];
        end
      end else begin
        hit = step[0] ? ({bemf, 8'h00} > neutral_fx) : ({bemf, 8'h00} < neutral_fx);
        if (armed && ticks != 16'd0 && hit) begin
          acc = (64'd39 * period_fx + 64'd512 * ticks + 64'd20) / 64'd40;
          period_fx = (acc > 64'hFF_FFFF) ? 24'hFF_FFFF : acc[23:0];
          armed = 1'b0;
          zc = 1'b1;
          crossings++;
        end
        acc = ({neu, 8'h00} + 64'd299 * neutral_fx + 64'd150) / 64'd300;
        neutral_fx = acc[SAMPLE_W+7:0];
      end
      r.phase = step;
      case (step)
        3'd1:    {r.high_gates, r.low_gates, r.sense_channel} = {3'd2, 3'd1, 2'd1};
        3'd2:    {r.high_gates, r.low_gates, r.sense_channel} = {3'd4, 3'd1, 2'd0};
        3'd3:    {r.high_gates, r.low_gates, r.sense_channel} = {3'd4, 3'd2, 2'd2};
        3'd4:    {r.high_gates, r.low_gates, r.sense_channel} = {3'd1, 3'd2, 2'd1};
        3'd5:    {r.high_gates, r.low_gates, r.sense_channel} = {3'd1, 3'd4, 2'd0};
        default: {r.high_gates, r.low_gates, r.sense_channel} = {3'd2, 3'd4, 2'd2};
      endcase
      r.period_ticks = rounded_period();
      r.zero_cross = zc;
      r.commutated = com;
      expected_q.push_back(r);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 20) $display("tb: mismatch: %s", what);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      compare_field("phase", got.phase, want.phase);
      compare_field("high_gates", got.high_gates, want.high_gates);
      compare_field("low_gates", got.low_gates, want.low_gates);
      compare_field("sense_channel", got.sense_channel, want.sense_channel);
      compare_field("period_ticks", got.period_ticks, want.period_ticks);
      compare_field("zero_cross", got.zero_cross, want.zero_cross);
      compare_field("commutated", got.commutated, want.commutated);
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [15:0]         cfg_wdata_i = 16'd0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                cmd_i = 1'b0;
  logic [SAMPLE_W-1:0] bemf_sample_i = '0;
  logic [SAMPLE_W-1:0] neutral_sample_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [2:0]          phase_o;
  logic [2:0]          high_gates_o;
  logic [2:0]          low_gates_o;
  logic [1:0]          sense_channel_o;
  logic [15:0]         period_ticks_o;
  logic                zero_cross_o;
  logic                commutated_o;

  commutation_scoreboard sb;
  result_t               seen;
  bit                    calm = 1'b0;
  int unsigned           cfg_writes = 0;

  sensorless_six_step_commutator_unit #(
    .SAMPLE_BITS(SAMPLE_W)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .bemf_sample_i   (bemf_sample_i),
    .neutral_sample_i(neutral_sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .phase_o         (phase_o),
    .high_gates_o    (high_gates_o),
    .low_gates_o     (low_gates_o),
    .sense_channel_o (sense_channel_o),
    .period_ticks_o  (period_ticks_o),
    .zero_cross_o    (zero_cross_o),
    .commutated_o    (commutated_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.phase = phase_o;
      seen.high_gates = high_gates_o;
      seen.low_gates = low_gates_o;
      seen.sense_channel = sense_channel_o;
      seen.period_ticks = period_ticks_o;
      seen.zero_cross = zero_cross_o;
      seen.commutated = commutated_o;
      sb.check_result(seen);
    end
  end

  task automatic send_request(cmd_e cmd, logic [SAMPLE_W-1:0] bemf,
                              logic [SAMPLE_W-1:0] neu);
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    bemf_sample_i <= bemf;
    neutral_sample_i <= neu;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(cmd, bemf, neu);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk_i);
    end
  endtask

  task automatic write_start_period(logic [15:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.load_period(v);
    cfg_writes++;
  endtask

  task automatic random_request(bit noisy, int neu_mid);
    cmd_e cmd;
    int   b;
    int   n;
    int   mid;
    bit   up;
    if (noisy) begin
      cmd = cmd_e'($urandom_range(1));
      b = $urandom_range(SAMPLE_MAX);
      n = $urandom_range(SAMPLE_MAX);
    end else begin
      cmd = ($urandom_range(99) < 60) ? CMD_TICK : CMD_SAMPLE;
      n = neu_mid - 150 + $urandom_range(300);
      mid = int'(sb.neutral_fx >> 8);
      up = (sb.step[0] == ($urandom_range(99) < 30));
      b = up ? mid + $urandom_range(300, 1) : mid - $urandom_range(300, 1);
      if (n < 0) n = 0;
      if (n > SAMPLE_MAX) n = SAMPLE_MAX;
      if (b < 0) b = 0;
      if (b > SAMPLE_MAX) b = SAMPLE_MAX;
    end
    send_request(cmd, b[SAMPLE_W-1:0], n[SAMPLE_W-1:0]);
  endtask

  initial begin
    int neu_mid;
    logic [SAMPLE_W-1:0] top;
    sb = new();
    top = SAMPLE_MAX[SAMPLE_W-1:0];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(CMD_TICK, '0, '0);
    send_request(CMD_SAMPLE, '0, '0);
    send_request(CMD_SAMPLE, top, top);
    send_request(CMD_SAMPLE, top, '0);
    send_request(CMD_SAMPLE, '0, top);

    write_start_period(16'd0);
    repeat (7) send_request(CMD_TICK, '0, '0);
    send_request(CMD_SAMPLE, '0, top);

    write_start_period(16'd3);
    send_request(CMD_TICK, '0, '0);
    send_request(CMD_SAMPLE, top, top);
    send_request(CMD_SAMPLE, top, '0);
    repeat (2) send_request(CMD_TICK, '0, '0);
    send_request(CMD_TICK, '0, '0);
    send_request(CMD_SAMPLE, '0, top);
    send_request(CMD_SAMPLE, '0, '0);

    for (int i = 0; i < 8; i++) begin
      write_start_period((i < 7) ? PHASE_PERIODS[i] : 16'($urandom_range(65535, 1000)));
      calm = (i == 3);
      neu_mid = $urandom_range(3800, 300);
      for (int k = 0; k < PHASE_ITEMS; k++) random_request($urandom_range(99) < 15, neu_mid);
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("tb: %0d requests checked with %0d start period writes", sb.requests, cfg_writes);
    $display("tb: %0d commutations and %0d zero crossings predicted",
             sb.commutations, sb.crossings);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
